// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REMOVE     = 3'd4,
    KIND_SEARCH     = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // control sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

// ===== hdl/bdq_in_if.sv =====
interface bdq_in_if;
  logic                        valid;
  logic                        ready;
  logic [bdq_pkg::KIND_W-1:0]  kind;
  logic signed [bdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== hdl/bdq_out_if.sv =====
interface bdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::STATUS_W-1:0]  status;
  logic [bdq_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

// ===== hdl/bdq_store.sv =====
module bdq_store #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic [$clog2(CAPACITY)-1:0] front,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_pos,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_pos,
  input  logic [bdq_pkg::DATA_W-1:0]  wr_data,
  output logic [bdq_pkg::DATA_W-1:0]  rd_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);

  logic [bdq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [SUM_W-1:0]           rd_sum;
  logic [SUM_W-1:0]           wr_sum;
  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           wr_addr;

  // logical position to physical slot, circular around the front
  assign rd_sum = SUM_W'(front) + SUM_W'(rd_pos);
  assign wr_sum = SUM_W'(front) + SUM_W'(wr_pos);

  always_comb begin
    rd_addr = (rd_sum >= CAP_S) ? IDX_W'(rd_sum - CAP_S) : IDX_W'(rd_sum);
    wr_addr = (wr_sum >= CAP_S) ? IDX_W'(wr_sum - CAP_S) : IDX_W'(wr_sum);
  end

  // element array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bounded_deque_with_value_search.sv =====
// Bounded double-ended queue of signed 32-bit values with remove and search by value,
// held in a single circular memory of CAPACITY words. Each request yields exactly one
// result with a status and the element count after the request. Pushes and pops pass
// from acceptance through the EXEC and RESP states to the result. Search and remove
// scan the elements through the single read port of the memory, one per cycle, in the
// order front, back, then the middle from the front, until a hit or the last element.
// A remove that hits an element in the middle then moves each later element one place
// forward, one element per cycle. A new request is taken once the previous one has its
// result in the output register; that register holds the result until it is taken.
module bounded_deque_with_value_search #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_req,
  bdq_out_if.source out_rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(CAPACITY - 1);

  bdq_pkg::state_t                  state_r, state_nxt;
  logic [bdq_pkg::KIND_W-1:0]       kind_r, kind_nxt;
  logic [bdq_pkg::DATA_W-1:0]       value_r, value_nxt;
  logic [IDX_W-1:0]                 front_r, front_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [CNT_W-1:0]                 k_r, k_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]                 rd_k_r, rd_k_nxt;
  logic [bdq_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic                             out_valid_r;
  logic [bdq_pkg::STATUS_W-1:0]     out_status_r;
  logic [bdq_pkg::COUNT_W-1:0]      out_count_r;

  logic                             mem_rd_en;
  logic [IDX_W-1:0]                 mem_rd_pos;
  logic                             mem_wr_en;
  logic [IDX_W-1:0]                 mem_wr_pos;
  logic [bdq_pkg::DATA_W-1:0]       mem_wr_data;
  logic [bdq_pkg::DATA_W-1:0]       mem_q;

  logic                             hit;
  logic                             last_rd;
  logic                             can_issue;
  logic [CNT_W-1:0]                 count_m1;
  logic [IDX_W-1:0]                 scan_pos;
  logic                             load_out;
  logic [CNT_W+bdq_pkg::COUNT_W-1:0] count_ext;

  bdq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .front   (front_r),
    .rd_en   (mem_rd_en),
    .rd_pos  (mem_rd_pos),
    .wr_en   (mem_wr_en),
    .wr_pos  (mem_wr_pos),
    .wr_data (mem_wr_data),
    .rd_data (mem_q)
  );

  // shared scan terms
  assign count_m1  = count_r - CNT_W'(1);
  assign hit       = rd_vld_r && (mem_q == value_r);
  assign last_rd   = rd_vld_r && (rd_k_r == count_m1);
  assign can_issue = (k_r < count_r);
  assign load_out  = (state_r == bdq_pkg::S_RESP) && (!out_valid_r || out_rsp.ready);
  assign count_ext = (CNT_W + bdq_pkg::COUNT_W)'(count_r);

  // scan order: front, back, then the middle from the front
  always_comb begin
    if (k_r == '0) begin
      scan_pos = '0;
    end else if (k_r == CNT_W'(1)) begin
      scan_pos = IDX_W'(count_m1);
    end else begin
      scan_pos = IDX_W'(k_r - CNT_W'(1));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        state_nxt = bdq_pkg::S_RESP;
        if ((kind_r == bdq_pkg::KIND_REMOVE || kind_r == bdq_pkg::KIND_SEARCH)
            && count_r != '0) begin
          state_nxt = bdq_pkg::S_SCAN;
        end
      end
      bdq_pkg::S_SCAN: begin
        if (hit) begin
          if (kind_r == bdq_pkg::KIND_SEARCH || rd_k_r < CNT_W'(2)) begin
            state_nxt = bdq_pkg::S_RESP;
          end else begin
            state_nxt = bdq_pkg::S_SHIFT;
          end
        end else if (last_rd) begin
          state_nxt = bdq_pkg::S_RESP;
        end
      end
      bdq_pkg::S_SHIFT: begin
        if (last_rd) begin
          state_nxt = bdq_pkg::S_RESP;
        end
      end
      bdq_pkg::S_RESP: begin
        if (load_out) begin
          state_nxt = bdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    rd_vld_nxt  = rd_vld_r;
    rd_k_nxt    = rd_k_r;
    status_nxt  = status_r;
    mem_rd_en   = 1'b0;
    mem_rd_pos  = scan_pos;
    mem_wr_en   = 1'b0;
    mem_wr_pos  = IDX_W'(count_r);
    mem_wr_data = value_r;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt  = in_req.kind;
          value_nxt = in_req.value;
        end
      end
      bdq_pkg::S_EXEC: begin
        status_nxt = bdq_pkg::ST_DONE;
        k_nxt      = '0;
        rd_vld_nxt = 1'b0;
        unique case (kind_r)
          bdq_pkg::KIND_PUSH_FRONT: begin
            if (count_r == CAP_C) begin
              status_nxt = bdq_pkg::ST_FULL;
            end else begin
              // one slot before the front
              mem_wr_en  = 1'b1;
              mem_wr_pos = LAST_I;
              front_nxt  = (front_r == '0) ? LAST_I : front_r - IDX_W'(1);
              count_nxt  = count_r + CNT_W'(1);
            end
          end
          bdq_pkg::KIND_PUSH_BACK: begin
            if (count_r == CAP_C) begin
              status_nxt = bdq_pkg::ST_FULL;
            end else begin
              mem_wr_en = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          bdq_pkg::KIND_POP_FRONT: begin
            if (count_r == '0) begin
              status_nxt = bdq_pkg::ST_EMPTY;
            end else begin
              front_nxt = (front_r == LAST_I) ? '0 : front_r + IDX_W'(1);
              count_nxt = count_m1;
            end
          end
          bdq_pkg::KIND_POP_BACK: begin
            if (count_r == '0) begin
              status_nxt = bdq_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_m1;
            end
          end
          bdq_pkg::KIND_REMOVE, bdq_pkg::KIND_SEARCH: begin
            if (count_r == '0) begin
              status_nxt = bdq_pkg::ST_EMPTY;
            end
          end
          default: ;
        endcase
      end
      bdq_pkg::S_SCAN: begin
        if (hit) begin
          status_nxt = bdq_pkg::ST_DONE;
          rd_vld_nxt = 1'b0;
          if (kind_r == bdq_pkg::KIND_REMOVE) begin
            if (rd_k_r == '0) begin
              front_nxt = (front_r == LAST_I) ? '0 : front_r + IDX_W'(1);
              count_nxt = count_m1;
            end else if (rd_k_r == CNT_W'(1)) begin
              count_nxt = count_m1;
            end else begin
              // middle hit at position rd_k_r - 1, start moving from the next one
              k_nxt = rd_k_r;
            end
          end
        end else if (last_rd) begin
          status_nxt = bdq_pkg::ST_NOTFOUND;
          rd_vld_nxt = 1'b0;
        end else if (can_issue) begin
          mem_rd_en  = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_k_nxt   = k_r;
          k_nxt      = k_r + CNT_W'(1);
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end
      bdq_pkg::S_SHIFT: begin
        // write the element read last cycle one place toward the front
        mem_wr_en   = rd_vld_r;
        mem_wr_pos  = IDX_W'(rd_k_r - CNT_W'(1));
        mem_wr_data = mem_q;
        mem_rd_pos  = IDX_W'(k_r);
        if (last_rd) begin
          count_nxt  = count_m1;
          rd_vld_nxt = 1'b0;
        end else if (can_issue) begin
          mem_rd_en  = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_k_nxt   = k_r;
          k_nxt      = k_r + CNT_W'(1);
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end
      bdq_pkg::S_RESP: ;
      default: ;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    k_r      <= k_nxt;
    rd_k_r   <= rd_k_nxt;
    status_r <= status_nxt;
    if (load_out) begin
      out_status_r <= status_r;
      out_count_r  <= count_ext[bdq_pkg::COUNT_W-1:0];
    end
  end

  // channel ports
  assign in_req.ready   = (state_r == bdq_pkg::S_IDLE);
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.count  = out_count_r;

endmodule
